[sv/hhci_pkg.sv]
// Package for the Henon-Heiles chaos integrator.
// Holds word format constants, action and register codes, payload structs
// and the saturating fixed-point helpers. No dependencies.
package hhci_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS     = 28;
    localparam int DT_BITS       = 29;
    localparam int ADDR_BITS     = 5;
    localparam int ACTION_BITS   = 3;
    localparam int SQRT_STEPS    = (WORD_BITS + FRAC_BITS) / 2;
    localparam int SQRT_CNT_BITS = $clog2(SQRT_STEPS);
    localparam int DIV3_SHIFT    = 33;

    localparam logic [ACTION_BITS-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_RESTART = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD_X  = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD_Y  = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD_YV = 3'd4;

    localparam logic [2:0] REG_START_X  = 3'd0;
    localparam logic [2:0] REG_START_Y  = 3'd1;
    localparam logic [2:0] REG_START_YV = 3'd2;
    localparam logic [2:0] REG_ENERGY   = 3'd3;
    localparam logic [2:0] REG_STEP     = 3'd4;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = 32'sh8000_0000;

    localparam logic signed [WORD_BITS-1:0] RST_START_X  = 32'sd268435456;
    localparam logic signed [WORD_BITS-1:0] RST_START_Y  = 32'sd268435456;
    localparam logic signed [WORD_BITS-1:0] RST_START_YV = 32'sd375809638;
    localparam logic signed [WORD_BITS-1:0] RST_ENERGY   = 32'sd33554432;
    localparam logic [DT_BITS-1:0]          RST_STEP     = 29'd5368709;
    localparam logic signed [WORD_BITS-1:0] RST_POS      = 32'sd268435456;
    localparam logic signed [WORD_BITS-1:0] RST_VEL_Y    = 32'sd375809638;

    // 1/3 as a 33-bit fraction; exact floor(n/3) for any 32-bit n
    localparam logic [WORD_BITS-1:0] DIV3_RECIP = 32'hAAAA_AAAB;
    localparam logic [2*WORD_BITS:0] RND_HALF   = (2*WORD_BITS+1)'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [ACTION_BITS-1:0]        action;
        logic signed [WORD_BITS-1:0]   load_value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] x_pos;
        logic signed [WORD_BITS-1:0] y_pos;
        logic signed [WORD_BITS-1:0] x_vel;
        logic signed [WORD_BITS-1:0] y_vel;
        logic                        radicand_negative;
        logic                        saturated;
    } t_out_item;

    typedef struct packed {
        logic                        clip;
        logic signed [WORD_BITS-1:0] value;
    } t_sat;

    function automatic logic [WORD_BITS-1:0] magnitude(input logic signed [WORD_BITS-1:0] a);
        magnitude = a[WORD_BITS-1] ? (WORD_BITS'(0) - a) : a;
    endfunction

    function automatic t_sat sat_addsub(input logic signed [WORD_BITS-1:0] a,
                                        input logic signed [WORD_BITS-1:0] b,
                                        input logic sub);
        logic signed [WORD_BITS:0] s;
        t_sat r;
        s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
                : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            r.clip  = 1'b1;
            r.value = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end else begin
            r.clip  = 1'b0;
            r.value = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

    // Round magnitude product to nearest (ties away from zero), apply sign, saturate
    function automatic t_sat round_product(input logic [2*WORD_BITS-1:0] prod,
                                           input logic neg);
        logic [2*WORD_BITS:0]          s;
        logic [2*WORD_BITS-FRAC_BITS:0] q;
        logic [2*WORD_BITS-FRAC_BITS:0] lim;
        t_sat r;
        s   = {1'b0, prod} + RND_HALF;
        q   = s[2*WORD_BITS:FRAC_BITS];
        lim = (2*WORD_BITS-FRAC_BITS+1)'(1) << (WORD_BITS - 1);
        if (!neg) begin
            lim = lim - (2*WORD_BITS-FRAC_BITS+1)'(1);
        end
        if (q > lim) begin
            r.clip  = 1'b1;
            r.value = neg ? WORD_MIN : WORD_MAX;
        end else begin
            r.clip  = 1'b0;
            r.value = neg ? (WORD_BITS'(0) - q[WORD_BITS-1:0]) : q[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[sv/henon_heiles_chaos_integrator.sv]
// Henon-Heiles chaos integrator top level: APB register file, sequencer,
// one shared multiplier with rounding stage, saturating adder and root unit.
// Depends on hhci_pkg.
//
// Chaotic signal source integrating the Henon-Heiles system by semi-implicit
// Euler in signed Q4.28, saturating at the range ends. Every input transaction
// returns one output transaction holding x, y, x', y' and two flags. A tick
// reports the state before the step and the saturation flag of that step; its
// work is seven products on the single shared 32x32 multiplier (multiply state,
// round state) and nine saturating add steps, then the output register is
// loaded. A restart reloads x, y, y' from the start registers and derives x'
// from the energy, running the 30-step bit-by-bit square root when the
// radicand is positive. Loads and unknown actions go straight to the done
// state. The input stalls while an item is in work and opens as the result is
// loaded; the output register lets a finished result wait while the next item
// runs.
module henon_heiles_chaos_integrator
    import hhci_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [40:0] {
        S_IDLE   = 41'b1 << 0,
        S_DONE   = 41'b1 << 1,
        S_A_XY_M = 41'b1 << 2,
        S_A_XY_R = 41'b1 << 3,
        S_A_XY2  = 41'b1 << 4,
        S_A_NEG  = 41'b1 << 5,
        S_A_XDD  = 41'b1 << 6,
        S_A_YY_M = 41'b1 << 7,
        S_A_YY_R = 41'b1 << 8,
        S_A_YDD1 = 41'b1 << 9,
        S_A_XX_M = 41'b1 << 10,
        S_A_XX_R = 41'b1 << 11,
        S_A_YDD2 = 41'b1 << 12,
        S_A_VX_M = 41'b1 << 13,
        S_A_VX_R = 41'b1 << 14,
        S_A_VX_A = 41'b1 << 15,
        S_A_VY_M = 41'b1 << 16,
        S_A_VY_R = 41'b1 << 17,
        S_A_VY_A = 41'b1 << 18,
        S_A_PX_M = 41'b1 << 19,
        S_A_PX_R = 41'b1 << 20,
        S_A_PX_A = 41'b1 << 21,
        S_A_PY_M = 41'b1 << 22,
        S_A_PY_R = 41'b1 << 23,
        S_A_PY_A = 41'b1 << 24,
        S_R_YY_M = 41'b1 << 25,
        S_R_YY_R = 41'b1 << 26,
        S_R_Y3_M = 41'b1 << 27,
        S_R_Y3_R = 41'b1 << 28,
        S_R_4A   = 41'b1 << 29,
        S_R_4B   = 41'b1 << 30,
        S_R_D3_M = 41'b1 << 31,
        S_R_D3_R = 41'b1 << 32,
        S_R_E2   = 41'b1 << 33,
        S_R_SUB  = 41'b1 << 34,
        S_R_ADD  = 41'b1 << 35,
        S_R_VV_M = 41'b1 << 36,
        S_R_VV_R = 41'b1 << 37,
        S_R_RAD  = 41'b1 << 38,
        S_R_CHK  = 41'b1 << 39,
        S_R_SQRT = 41'b1 << 40
    } t_state;

    localparam int SQ_NUM_BITS  = 2 * SQRT_STEPS;
    localparam int SQ_ROOT_BITS = SQRT_STEPS;
    localparam int SQ_REM_BITS  = SQRT_STEPS + 4;

    t_state r_state, n_state;

    // configuration
    logic signed [WORD_BITS-1:0] r_start_x, r_start_y, r_start_yv, r_energy;
    logic [DT_BITS-1:0]          r_step_size;

    // integrator state and flags
    logic signed [WORD_BITS-1:0] r_px, r_py, r_vx, r_vy;
    logic                        r_radneg, r_sat;

    // work registers
    logic signed [WORD_BITS-1:0] r_snap_px, r_snap_py, r_snap_vx, r_snap_vy;
    logic                        r_tick;
    logic                        r_clip;
    logic signed [WORD_BITS-1:0] r_p, r_t0, r_t1;
    logic [2*WORD_BITS-1:0]      r_prod;
    logic                        r_neg;

    // root unit
    logic [SQ_NUM_BITS-1:0]      r_sq_num;
    logic [SQ_ROOT_BITS-1:0]     r_sq_root;
    logic [SQ_REM_BITS-1:0]      r_sq_rem;
    logic [SQRT_CNT_BITS-1:0]    r_sq_cnt;

    // output register
    logic                        r_out_valid;
    t_out_item                   r_out;

    logic                        w_in_acc;
    logic                        w_out_free;
    logic                        w_cfg_wr;
    logic [2:0]                  w_cfg_idx;
    logic [WORD_BITS-1:0]        w_mul_a, w_mul_b;
    logic                        w_mul_neg;
    logic signed [WORD_BITS-1:0] w_alu_a, w_alu_b;
    logic                        w_alu_sub;
    t_sat                        w_alu, w_rnd;
    logic signed [WORD_BITS-1:0] w_dt;
    logic [WORD_BITS-2:0]        w_q3;
    logic [SQ_REM_BITS-1:0]      w_sq_sh, w_sq_trial;
    logic                        w_sq_take;
    logic [SQ_ROOT_BITS-1:0]     w_sq_root_nx;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign w_cfg_idx   = paddr[ADDR_BITS-1:2];
    assign w_dt        = WORD_BITS'(r_step_size);

    always_comb begin
        unique case (w_cfg_idx)
            REG_START_X:  prdata = r_start_x;
            REG_START_Y:  prdata = r_start_y;
            REG_START_YV: prdata = r_start_yv;
            REG_ENERGY:   prdata = r_energy;
            REG_STEP:     prdata = 32'(r_step_size);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x   <= RST_START_X;
            r_start_y   <= RST_START_Y;
            r_start_yv  <= RST_START_YV;
            r_energy    <= RST_ENERGY;
            r_step_size <= RST_STEP;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_START_X:  r_start_x   <= pwdata;
                REG_START_Y:  r_start_y   <= pwdata;
                REG_START_YV: r_start_yv  <= pwdata;
                REG_ENERGY:   r_energy    <= pwdata;
                REG_STEP:     r_step_size <= pwdata[DT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select (magnitudes and product sign)
    always_comb begin
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_mul_neg = 1'b0;
        unique case (r_state)
            S_A_XY_M: begin
                w_mul_a   = magnitude(r_px);
                w_mul_b   = magnitude(r_py);
                w_mul_neg = r_px[WORD_BITS-1] ^ r_py[WORD_BITS-1];
            end
            S_A_YY_M, S_R_YY_M: begin
                w_mul_a = magnitude(r_py);
                w_mul_b = magnitude(r_py);
            end
            S_A_XX_M: begin
                w_mul_a = magnitude(r_px);
                w_mul_b = magnitude(r_px);
            end
            S_A_VX_M: begin
                w_mul_a   = magnitude(r_t1);
                w_mul_b   = w_dt;
                w_mul_neg = r_t1[WORD_BITS-1];
            end
            S_A_VY_M: begin
                w_mul_a   = magnitude(r_t0);
                w_mul_b   = w_dt;
                w_mul_neg = r_t0[WORD_BITS-1];
            end
            S_A_PX_M: begin
                w_mul_a   = magnitude(r_vx);
                w_mul_b   = w_dt;
                w_mul_neg = r_vx[WORD_BITS-1];
            end
            S_A_PY_M: begin
                w_mul_a   = magnitude(r_vy);
                w_mul_b   = w_dt;
                w_mul_neg = r_vy[WORD_BITS-1];
            end
            S_R_Y3_M: begin
                w_mul_a   = magnitude(r_p);
                w_mul_b   = magnitude(r_py);
                w_mul_neg = r_p[WORD_BITS-1] ^ r_py[WORD_BITS-1];
            end
            S_R_VV_M: begin
                w_mul_a = magnitude(r_vy);
                w_mul_b = magnitude(r_vy);
            end
            S_R_D3_M: begin
                w_mul_a   = magnitude(r_t1) + WORD_BITS'(1);
                w_mul_b   = DIV3_RECIP;
                w_mul_neg = r_t1[WORD_BITS-1];
            end
            default: ;
        endcase
    end

    // shared saturating adder operand select
    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        unique case (r_state)
            S_A_XY2:  begin w_alu_a = r_p;  w_alu_b = r_p;                    end
            S_A_NEG:  begin w_alu_a = '0;   w_alu_b = r_px; w_alu_sub = 1'b1; end
            S_A_XDD:  begin w_alu_a = r_t1; w_alu_b = r_t0; w_alu_sub = 1'b1; end
            S_A_YDD1: begin w_alu_a = r_p;  w_alu_b = r_py; w_alu_sub = 1'b1; end
            S_A_YDD2: begin w_alu_a = r_t0; w_alu_b = r_p;  w_alu_sub = 1'b1; end
            S_A_VX_A: begin w_alu_a = r_vx; w_alu_b = r_p;                    end
            S_A_VY_A: begin w_alu_a = r_vy; w_alu_b = r_p;                    end
            S_A_PX_A: begin w_alu_a = r_px; w_alu_b = r_p;                    end
            S_A_PY_A: begin w_alu_a = r_py; w_alu_b = r_p;                    end
            S_R_4A:   begin w_alu_a = r_p;  w_alu_b = r_p;                    end
            S_R_4B:   begin w_alu_a = r_t1; w_alu_b = r_t1;                   end
            S_R_E2:   begin w_alu_a = r_energy; w_alu_b = r_energy;           end
            S_R_SUB:  begin w_alu_a = r_p;  w_alu_b = r_t0; w_alu_sub = 1'b1; end
            S_R_ADD:  begin w_alu_a = r_t0; w_alu_b = r_t1;                   end
            S_R_RAD:  begin w_alu_a = r_t0; w_alu_b = r_p;  w_alu_sub = 1'b1; end
            default: ;
        endcase
    end

    assign w_alu = sat_addsub(w_alu_a, w_alu_b, w_alu_sub);
    assign w_rnd = round_product(r_prod, r_neg);
    assign w_q3  = r_prod[2*WORD_BITS-1:DIV3_SHIFT];

    // one restoring square-root digit
    assign w_sq_sh      = {r_sq_rem[SQ_REM_BITS-3:0], r_sq_num[SQ_NUM_BITS-1 -: 2]};
    assign w_sq_trial   = SQ_REM_BITS'({r_sq_root, 2'b01});
    assign w_sq_take    = (w_sq_sh >= w_sq_trial);
    assign w_sq_root_nx = {r_sq_root[SQ_ROOT_BITS-2:0], w_sq_take};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in_data.action)
                        ACT_TICK:    n_state = S_A_XY_M;
                        ACT_RESTART: n_state = S_R_YY_M;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            S_A_XY_M: n_state = S_A_XY_R;
            S_A_XY_R: n_state = S_A_XY2;
            S_A_XY2:  n_state = S_A_NEG;
            S_A_NEG:  n_state = S_A_XDD;
            S_A_XDD:  n_state = S_A_YY_M;
            S_A_YY_M: n_state = S_A_YY_R;
            S_A_YY_R: n_state = S_A_YDD1;
            S_A_YDD1: n_state = S_A_XX_M;
            S_A_XX_M: n_state = S_A_XX_R;
            S_A_XX_R: n_state = S_A_YDD2;
            S_A_YDD2: n_state = S_A_VX_M;
            S_A_VX_M: n_state = S_A_VX_R;
            S_A_VX_R: n_state = S_A_VX_A;
            S_A_VX_A: n_state = S_A_VY_M;
            S_A_VY_M: n_state = S_A_VY_R;
            S_A_VY_R: n_state = S_A_VY_A;
            S_A_VY_A: n_state = S_A_PX_M;
            S_A_PX_M: n_state = S_A_PX_R;
            S_A_PX_R: n_state = S_A_PX_A;
            S_A_PX_A: n_state = S_A_PY_M;
            S_A_PY_M: n_state = S_A_PY_R;
            S_A_PY_R: n_state = S_A_PY_A;
            S_A_PY_A: n_state = S_DONE;
            S_R_YY_M: n_state = S_R_YY_R;
            S_R_YY_R: n_state = S_R_Y3_M;
            S_R_Y3_M: n_state = S_R_Y3_R;
            S_R_Y3_R: n_state = S_R_4A;
            S_R_4A:   n_state = S_R_4B;
            S_R_4B:   n_state = S_R_D3_M;
            S_R_D3_M: n_state = S_R_D3_R;
            S_R_D3_R: n_state = S_R_E2;
            S_R_E2:   n_state = S_R_SUB;
            S_R_SUB:  n_state = S_R_ADD;
            S_R_ADD:  n_state = S_R_VV_M;
            S_R_VV_M: n_state = S_R_VV_R;
            S_R_VV_R: n_state = S_R_RAD;
            S_R_RAD:  n_state = S_R_CHK;
            S_R_CHK: begin
                if (!r_t0[WORD_BITS-1] && (r_t0 != '0)) n_state = S_R_SQRT;
                else                                    n_state = S_DONE;
            end
            S_R_SQRT: begin
                if (r_sq_cnt == SQRT_CNT_BITS'(SQRT_STEPS - 1)) n_state = S_DONE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        r_neg  <= w_mul_neg;
    end

    // state, flags and work registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px     <= RST_POS;
            r_py     <= RST_POS;
            r_vx     <= '0;
            r_vy     <= RST_VEL_Y;
            r_radneg <= 1'b0;
            r_sat    <= 1'b0;
            r_tick   <= 1'b0;
            r_clip   <= 1'b0;
            r_sq_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_snap_px <= r_px;
                        r_snap_py <= r_py;
                        r_snap_vx <= r_vx;
                        r_snap_vy <= r_vy;
                        r_tick    <= (i_in_data.action == ACT_TICK);
                        r_clip    <= 1'b0;
                        unique case (i_in_data.action)
                            ACT_RESTART: begin
                                r_px <= r_start_x;
                                r_py <= r_start_y;
                                r_vy <= r_start_yv;
                            end
                            ACT_LOAD_X:  r_px <= i_in_data.load_value;
                            ACT_LOAD_Y:  r_py <= i_in_data.load_value;
                            ACT_LOAD_YV: r_vy <= i_in_data.load_value;
                            default: ;
                        endcase
                    end
                end
                S_A_XY_R, S_A_YY_R, S_A_XX_R, S_A_VX_R, S_A_VY_R, S_A_PX_R, S_A_PY_R,
                S_R_YY_R, S_R_Y3_R, S_R_VV_R: begin
                    r_p    <= w_rnd.value;
                    r_clip <= r_clip | w_rnd.clip;
                end
                S_A_XY2: begin
                    r_t0   <= w_alu.value;
                    r_clip <= r_clip | w_alu.clip;
                end
                S_A_NEG, S_A_XDD, S_R_4A, S_R_4B: begin
                    r_t1   <= w_alu.value;
                    r_clip <= r_clip | w_alu.clip;
                end
                S_A_YDD1, S_A_YDD2, S_R_SUB, S_R_ADD, S_R_RAD: begin
                    r_t0   <= w_alu.value;
                    r_clip <= r_clip | w_alu.clip;
                end
                S_A_VX_A: begin
                    r_vx   <= w_alu.value;
                    r_clip <= r_clip | w_alu.clip;
                end
                S_A_VY_A: begin
                    r_vy   <= w_alu.value;
                    r_clip <= r_clip | w_alu.clip;
                end
                S_A_PX_A: begin
                    r_px   <= w_alu.value;
                    r_clip <= r_clip | w_alu.clip;
                end
                S_A_PY_A: begin
                    r_py  <= w_alu.value;
                    r_sat <= r_clip | w_alu.clip;
                end
                S_R_Y3_M: r_t0 <= r_p;
                S_R_D3_R: begin
                    r_t1 <= r_neg ? (WORD_BITS'(0) - {1'b0, w_q3}) : {1'b0, w_q3};
                end
                S_R_E2: r_p <= w_alu.value;
                S_R_CHK: begin
                    r_radneg  <= r_t0[WORD_BITS-1];
                    r_sq_num  <= {r_t0, FRAC_BITS'(0)};
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_sq_cnt  <= '0;
                    if (r_t0[WORD_BITS-1] || (r_t0 == '0)) begin
                        r_vx <= '0;
                    end
                end
                S_R_SQRT: begin
                    r_sq_num  <= {r_sq_num[SQ_NUM_BITS-3:0], 2'b00};
                    r_sq_rem  <= w_sq_take ? (w_sq_sh - w_sq_trial) : w_sq_sh;
                    r_sq_root <= w_sq_root_nx;
                    r_sq_cnt  <= r_sq_cnt + SQRT_CNT_BITS'(1);
                    if (r_sq_cnt == SQRT_CNT_BITS'(SQRT_STEPS - 1)) begin
                        r_vx <= WORD_BITS'(w_sq_root_nx);
                    end
                end
                default: ;
            endcase
        end
    end

    // output register: tick reports the state from before the step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.x_pos             <= r_tick ? r_snap_px : r_px;
            r_out.y_pos             <= r_tick ? r_snap_py : r_py;
            r_out.x_vel             <= r_tick ? r_snap_vx : r_vx;
            r_out.y_vel             <= r_tick ? r_snap_vy : r_vy;
            r_out.radicand_negative <= r_radneg;
            r_out.saturated         <= r_sat;
        end
    end

endmodule
